// ----- rtl/core/utf8vf_pkg.sv -----
// Package with the shared types, constants and decode functions of the UTF-8 visible filter.
package utf8vf_pkg;

  // Number of groups the front-to-back queue holds.
  localparam int unsigned QDepth = 2;

  // One group: the bytes kept for one input beat, handed from front to back.
  // A count of zero marks a bare end marker.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            eot;
  } grp_t;

  // Sequence length announced by a head byte; zero for a byte that cannot lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Visible ranges of two-byte characters.
  function automatic logic vis2(input logic [7:0] b0, input logic [7:0] b1);
    logic [10:0] cp;
    cp = {b0[4:0], b1[5:0]};
    return (cp >= 11'h0A0 && cp <= 11'h2AF) || (cp >= 11'h370 && cp <= 11'h6FF);
  endfunction

  // Visible ranges of three-byte characters.
  function automatic logic vis3(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2);
    logic [15:0] cp;
    cp = {b0[3:0], b1[5:0], b2[5:0]};
    return (cp >= 16'h2000 && cp <= 16'h20CF) || (cp >= 16'h2200 && cp <= 16'h243F)
        || (cp >= 16'h25A0 && cp <= 16'h26FF) || (cp >= 16'h3000 && cp <= 16'h318F)
        || (cp >= 16'h4E00 && cp <= 16'h9FFF) || (cp >= 16'hAC00 && cp <= 16'hD7AF)
        || (cp >= 16'hF900 && cp <= 16'hFDFF) || (cp >= 16'hFE20 && cp <= 16'hFFEF);
  endfunction

  // Visible ranges of four-byte characters.
  function automatic logic vis4(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] b3);
    logic [20:0] cp;
    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    return (cp >= 21'h1F300 && cp <= 21'h1F64F) || (cp >= 21'h1F680 && cp <= 21'h1F6FF)
        || (cp >= 21'h1F900 && cp <= 21'h1F9FF) || (cp >= 21'h20000 && cp <= 21'h2A6DF)
        || (cp >= 21'h2A700 && cp <= 21'h2B81F) || (cp >= 21'h2F800 && cp <= 21'h2FA1F);
  endfunction

endpackage

// ----- rtl/core/utf8vf_if.sv -----
// Stream interfaces for the input bytes and the filtered output bytes.
interface utf8vf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utf8vf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input text_done, output ready);
endinterface

// ----- rtl/core/utf8_visible_char_filter.sv -----
// Top level of the UTF-8 visible character filter.
//
//   Channel  Dir  Beat contents                              Accepted when
//   in_i     in   in_byte, end_of_text                       valid && ready
//   out_o    out  out_byte, byte_valid, run_last, text_done  valid && ready
//
// An input beat is scanned in the cycle it is accepted; the front end takes a
// beat every cycle while the two-group queue has room. The back end sends one
// output beat per cycle while out_o is not stalled, one beat for each kept byte
// (one for a bare end marker); its output register sets the output rate.
// Reset empties the lookahead store, the queue and the output register.
// A stall on the output fills the queue and then drops in_i.ready.
module utf8_visible_char_filter
  import utf8vf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  utf8vf_in_if.sink        in_i,
  utf8vf_out_if.source     out_o
);

  logic push;
  grp_t push_grp;
  logic q_full;
  logic pop;
  logic q_avail;
  grp_t q_head;

  utf8vf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.in_byte),
    .in_eot_i   (in_i.end_of_text),
    .push_o     (push),
    .push_grp_o (push_grp),
    .q_full_i   (q_full)
  );

  utf8vf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .full_o     (q_full),
    .pop_i      (pop),
    .avail_o    (q_avail),
    .head_o     (q_head)
  );

  utf8vf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_avail_i    (q_avail),
    .q_head_i     (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .byte_valid_o (out_o.byte_valid),
    .run_last_o   (out_o.run_last),
    .text_done_o  (out_o.text_done)
  );

endmodule

// ----- rtl/core/utf8vf_front.sv -----
// Front end: holds the pending lookahead bytes and scans each beat into a kept group.
module utf8vf_front
  import utf8vf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_eot_i,
  output logic       push_o,
  output grp_t       push_grp_o,
  input  logic       q_full_i
);

  logic [1:0]      cnt_q, cnt_d;
  logic [2:0][7:0] pend_q, pend_d;
  logic [3:0][7:0] w;
  logic [3:0][2:0] len;
  logic [3:0]      v2, v3, v4;
  logic [2:0]      n;
  logic [2:0]      pos;
  logic            stop;
  logic [3:0]      keep;
  logic [2:0]      nk;
  logic [3:0][7:0] kept;
  logic            accept;
  logic [1:0]      p;
  logic [2:0]      need;
  logic [2:0]      avail;
  logic [2:0]      span_end;
  logic            ok;
  logic [2:0]      idx;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign n          = {1'b0, cnt_q} + 3'd1;

  // Working window: pending bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = (2'(i) == cnt_q) ? in_byte_i : pend_q[i];
    end
    w[3] = in_byte_i;
  end

  // Length and visibility of a sequence at every start position, in parallel.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      len[i] = seq_len(w[i]);
    end
    v2 = {1'b0, vis2(w[2], w[3]), vis2(w[1], w[2]), vis2(w[0], w[1])};
    v3 = {2'b00, vis3(w[1], w[2], w[3]), vis3(w[0], w[1], w[2])};
    v4 = {3'b000, vis4(w[0], w[1], w[2], w[3])};
  end

  // Scan of the window, at most four steps, marking the kept bytes.
  always_comb begin
    pos      = 3'd0;
    stop     = 1'b0;
    keep     = 4'b0000;
    p        = 2'd0;
    need     = 3'd0;
    avail    = 3'd0;
    span_end = 3'd0;
    ok       = 1'b0;
    for (int s = 0; s < 4; s++) begin
      if (!stop && pos < n) begin
        p     = pos[1:0];
        need  = len[p];
        avail = n - pos;
        unique case (need)
          3'd2:    ok = v2[p];
          3'd3:    ok = v3[p];
          3'd4:    ok = v4[p];
          default: ok = 1'b0;
        endcase
        if (need == 3'd0) begin
          pos = pos + 3'd1;
        end else if (need == 3'd1) begin
          keep[p] = 1'b1;
          pos     = pos + 3'd1;
        end else if (avail < need) begin
          // An incomplete sequence waits, unless the text ends here.
          if (in_eot_i) begin
            pos = pos + 3'd1;
          end else begin
            stop = 1'b1;
          end
        end else if (ok) begin
          span_end = {1'b0, p} + need;
          for (int j = 0; j < 4; j++) begin
            if (3'(j) >= {1'b0, p} && 3'(j) < span_end) begin
              keep[j] = 1'b1;
            end
          end
          pos = pos + need;
        end else begin
          pos = pos + 3'd1;
        end
      end
    end
  end

  // Pack the kept bytes in order.
  always_comb begin
    nk   = 3'd0;
    kept = '0;
    for (int i = 0; i < 4; i++) begin
      if (keep[i]) begin
        kept[nk[1:0]] = w[i];
        nk            = nk + 3'd1;
      end
    end
  end

  // Bytes that stay pending move to the front of the store.
  always_comb begin
    cnt_d  = 2'(n - pos);
    pend_d = pend_q;
    idx    = 3'd0;
    for (int i = 0; i < 3; i++) begin
      idx = pos + 3'(i);
      if (idx < 3'd4) begin
        pend_d[i] = w[idx[1:0]];
      end
    end
  end

  assign push_o           = accept && (nk != 3'd0 || in_eot_i);
  assign push_grp_o.bytes = kept;
  assign push_grp_o.cnt   = nk;
  assign push_grp_o.eot   = in_eot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ----- rtl/core/utf8vf_queue.sv -----
// Short queue of kept groups between the front end and the back end.
module utf8vf_queue
  import utf8vf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t push_grp_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output grp_t head_o
);

  localparam int unsigned PtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned FillW = $clog2(QDepth + 1);

  grp_t             mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [FillW-1:0] fill_q;

  assign full_o  = (fill_q == FillW'(QDepth));
  assign avail_o = (fill_q != '0);
  assign head_o  = mem_q[rd_q];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FillW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

endmodule

// ----- rtl/core/utf8vf_back.sv -----
// Back end: unrolls each kept group into output beats through a registered stage.
module utf8vf_back
  import utf8vf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_avail_i,
  input  grp_t       q_head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  grp_t       cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       obv_q, olast_q, odone_q;
  logic       load_out;
  logic       last;
  logic       emit;

  // The output register takes a new beat when it is empty or being drained.
  assign load_out = !ovalid_q || out_ready_i;
  assign emit     = busy_q && load_out;
  assign last     = (cur_q.cnt == 3'd0) || ({1'b0, idx_q} == cur_q.cnt - 3'd1);
  assign pop_o    = q_avail_i && (!busy_q || (emit && last));

  // Group walker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (emit) begin
      if (last) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
  end

  // Output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= (cur_q.cnt == 3'd0) ? 8'h00 : cur_q.bytes[idx_q];
      obv_q   <= (cur_q.cnt != 3'd0);
      olast_q <= last;
      odone_q <= last && cur_q.eot;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign byte_valid_o = obv_q;
  assign run_last_o   = olast_q;
  assign text_done_o  = odone_q;

endmodule
